// ===== src/sha1_pkg.sv =====
// sha1_pkg: shared types, constants and helpers of the sha-1 digest block
// no dependencies; used by sha1_sched, sha1_round and sha1_message_digest
`default_nettype none

package sha1_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS   = 80;

   // initial chaining words, h0 in the lowest slot
   localparam logic [4:0][31:0] SHA1_IV = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   // round constants, one for each group of twenty rounds
   localparam logic [3:0][31:0] SHA1_K = {
      32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
   };

   // padding marker byte placed as the leading byte of a word
   localparam logic [31:0] PAD_MARK = 32'h8000_0000;

   // round function selectors
   localparam logic [1:0] PHASE_CH  = 2'd0;
   localparam logic [1:0] PHASE_PAR = 2'd1;
   localparam logic [1:0] PHASE_MAJ = 2'd2;
   localparam logic [1:0] PHASE_END = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } sha1_state_type;

   // sequencer controls for the schedule and round datapath
   typedef struct packed {
      logic       load;   // copy chaining words into the working set
      logic       step;   // run one round
      logic       early;  // round below sixteen, schedule word taken as is
      logic [1:0] phase;  // round function group
      logic       fold;   // add working set into chaining words
      logic       init;   // restore initial chaining words
   } sha1_round_ctl_type;

   // mask that keeps the leading count bytes of a word
   function automatic logic [31:0] keep_mask(input logic [2:0] cnt);
      logic [31:0] m;
      unique case (cnt)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'hFF00_0000;
         3'd2:    m = 32'hFFFF_0000;
         3'd3:    m = 32'hFFFF_FF00;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== src/sha1_sched.sv =====
// sha1_sched: sixteen-word block buffer doubling as the message schedule window
// depends on sha1_pkg
`default_nettype none

module sha1_sched (
   input  wire logic                         clock,
   input  wire logic                         push_en,
   input  wire logic [31:0]                  push_word,
   input  wire sha1_pkg::sha1_round_ctl_type ctl,
   output logic [31:0]                       sched_word
);

   logic [sha1_pkg::BLOCK_WORDS-1:0][31:0] sched_ff;
   logic [sha1_pkg::BLOCK_WORDS-1:0][31:0] sched_in;
   logic [31:0] expand;

   // slot 0 holds the oldest word of the window
   always_comb begin
      expand     = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      sched_word = ctl.early ? sched_ff[0] : {expand[30:0], expand[31]};
      sched_in   = sched_ff;
      if (push_en) begin
         sched_in = {push_word, sched_ff[sha1_pkg::BLOCK_WORDS-1:1]};
      end else if (ctl.step) begin
         sched_in = {sched_word, sched_ff[sha1_pkg::BLOCK_WORDS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
   end

endmodule

`default_nettype wire

// ===== src/sha1_round.sv =====
// sha1_round: shared round unit with working words and chaining words
// depends on sha1_pkg
`default_nettype none

module sha1_round (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sha1_pkg::sha1_round_ctl_type ctl,
   input  wire logic [31:0]                  sched_word,
   output logic [4:0][31:0]                  chain
);

   logic [4:0][31:0] work_ff;
   logic [4:0][31:0] work_in;
   logic [4:0][31:0] chain_ff;
   logic [4:0][31:0] chain_in;
   logic [31:0] a, b, c, d, e;
   logic [31:0] f;
   logic [31:0] t;

   always_comb begin
      a = work_ff[0];
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      e = work_ff[4];
      unique case (ctl.phase)
         sha1_pkg::PHASE_CH:  f = (b & c) | (~b & d);
         sha1_pkg::PHASE_MAJ: f = (b & c) | (b & d) | (c & d);
         sha1_pkg::PHASE_PAR,
         sha1_pkg::PHASE_END: f = b ^ c ^ d;
         default:             f = b ^ c ^ d;
      endcase
      t = {a[26:0], a[31:27]} + f + e + sched_word + sha1_pkg::SHA1_K[ctl.phase];

      work_in  = work_ff;
      chain_in = chain_ff;
      if (ctl.load) begin
         work_in = chain_ff;
      end
      if (ctl.step) begin
         work_in = {d, c, {b[1:0], b[31:2]}, a, t};
      end
      if (ctl.fold) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (ctl.init) begin
         chain_in = sha1_pkg::SHA1_IV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1_pkg::SHA1_IV;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign chain = chain_ff;

endmodule

`default_nettype wire

// ===== src/sha1_message_digest.sv =====
// sha1_message_digest: streaming sha-1, byte packing, padding, sequencer, output
// depends on sha1_pkg, sha1_sched, sha1_round
//
//  channel | dir | beat fields (tdata low bit first)              | end mark
//  req_    | in  | data_word[31:0], byte_count[34:32], zero pad   | tlast = final_item
//  rsp_    | out | digest_word[31:0]                              | tlast = last_digest_word
//
//  a beat that fills the 64-byte block holds the input for 80 rounds of the single
//  round unit and a fold; the final beat adds a marker step, a step per zero word,
//  a step to leave the zero fill, the two length words, a compression per full block
//  and then 5 digest beats; synchronous active-high reset restores the initial
//  chaining words and empties the buffer; digest beats hold while rsp_tready is low,
//  and the next message is taken once the last digest word is in the output register
`default_nettype none

module sha1_message_digest (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // data_word[31:0], byte_count[34:32], zeros
   input  wire logic        req_tlast,  // final_item
   // digest stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // digest_word[31:0]
   output logic             rsp_tlast   // last_digest_word
);

   sha1_pkg::sha1_state_type state_ff, state_in;
   sha1_pkg::sha1_state_type resume_ff, resume_in;
   sha1_pkg::sha1_state_type after;
   sha1_pkg::sha1_round_ctl_type ctl;

   logic [6:0]  round_ff, round_in;
   logic [3:0]  word_cnt_ff, word_cnt_in;   // full words held in the block buffer
   logic [1:0]  off_ff, off_in;             // bytes held in the partial word
   logic [31:0] partial_ff, partial_in;
   logic [63:0] bit_len_ff, bit_len_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        accept;
   logic [2:0]  in_cnt;
   logic [2:0]  mrg_cnt;
   logic [31:0] mrg_data;
   logic [63:0] mrg_acc;
   logic [2:0]  mrg_total;
   logic        merge_en;
   logic        push_en;
   logic [31:0] push_word;
   logic        block_full;
   logic        pad_done;
   logic        emit;
   logic        last_emit;
   logic [31:0] sched_word;
   logic [4:0][31:0] chain;

   assign req_tready = (state_ff == sha1_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   // byte packer: merge new leading bytes behind the partial word
   always_comb begin
      in_cnt    = (req_tdata[34:32] > 3'd4) ? 3'd4 : req_tdata[34:32];
      mrg_cnt   = (state_ff == sha1_pkg::ST_MARK) ? 3'd1 : in_cnt;
      mrg_data  = (state_ff == sha1_pkg::ST_MARK) ? sha1_pkg::PAD_MARK : req_tdata[31:0];
      mrg_acc   = {partial_ff, 32'h0}
                | ({mrg_data & sha1_pkg::keep_mask(mrg_cnt), 32'h0} >> {off_ff, 3'b000});
      mrg_total = {1'b0, off_ff} + mrg_cnt;
      pad_done  = (word_cnt_ff == 4'd14) && (off_ff == 2'd0);
      emit      = !rsp_valid_ff || rsp_tready;
      last_emit = emit && (out_idx_ff == 3'd4);
   end

   // sequencer outputs
   always_comb begin
      merge_en  = 1'b0;
      push_en   = 1'b0;
      push_word = mrg_acc[63:32];
      after     = state_ff;
      ctl       = '0;
      ctl.early = (round_ff < 7'd16);
      if (round_ff < 7'd20) begin
         ctl.phase = sha1_pkg::PHASE_CH;
      end else if (round_ff < 7'd40) begin
         ctl.phase = sha1_pkg::PHASE_PAR;
      end else if (round_ff < 7'd60) begin
         ctl.phase = sha1_pkg::PHASE_MAJ;
      end else begin
         ctl.phase = sha1_pkg::PHASE_END;
      end
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            merge_en = accept;
            push_en  = accept && mrg_total[2];
            if (accept) begin
               after = req_tlast ? sha1_pkg::ST_MARK : sha1_pkg::ST_IDLE;
            end
         end
         sha1_pkg::ST_MARK: begin
            merge_en = 1'b1;
            push_en  = mrg_total[2];
            after    = sha1_pkg::ST_ZERO;
         end
         sha1_pkg::ST_ZERO: begin
            push_en   = !pad_done;
            push_word = partial_ff;
            after     = pad_done ? sha1_pkg::ST_LEN_HI : sha1_pkg::ST_ZERO;
         end
         sha1_pkg::ST_LEN_HI: begin
            push_en   = 1'b1;
            push_word = bit_len_ff[63:32];
            after     = sha1_pkg::ST_LEN_LO;
         end
         sha1_pkg::ST_LEN_LO: begin
            push_en   = 1'b1;
            push_word = bit_len_ff[31:0];
            after     = sha1_pkg::ST_OUT;
         end
         sha1_pkg::ST_ROUND: ctl.step = 1'b1;
         sha1_pkg::ST_FOLD:  ctl.fold = 1'b1;
         sha1_pkg::ST_OUT:   ctl.init = last_emit;
         default: ;
      endcase
      block_full = push_en && (word_cnt_ff == 4'd15);
      ctl.load   = block_full;
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      resume_in = resume_ff;
      unique case (state_ff)
         sha1_pkg::ST_IDLE,
         sha1_pkg::ST_MARK,
         sha1_pkg::ST_ZERO,
         sha1_pkg::ST_LEN_HI,
         sha1_pkg::ST_LEN_LO: begin
            if (block_full) begin
               state_in  = sha1_pkg::ST_ROUND;
               resume_in = after;
            end else begin
               state_in = after;
            end
         end
         sha1_pkg::ST_ROUND: begin
            if (round_ff == 7'(sha1_pkg::ROUNDS - 1)) begin
               state_in = sha1_pkg::ST_FOLD;
            end
         end
         sha1_pkg::ST_FOLD: state_in = resume_ff;
         sha1_pkg::ST_OUT: begin
            if (last_emit) begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
   end

   // counters, packer and digest register
   always_comb begin
      round_in    = round_ff;
      word_cnt_in = word_cnt_ff;
      off_in      = off_ff;
      partial_in  = partial_ff;
      bit_len_in  = bit_len_ff;
      out_idx_in  = out_idx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (state_ff == sha1_pkg::ST_ROUND) begin
         round_in = (round_ff == 7'(sha1_pkg::ROUNDS - 1)) ? 7'd0 : round_ff + 7'd1;
      end
      if (push_en) begin
         word_cnt_in = word_cnt_ff + 4'd1;   // wraps to zero on a full block
      end
      if (merge_en) begin
         off_in     = mrg_total[1:0];
         partial_in = mrg_total[2] ? mrg_acc[31:0] : mrg_acc[63:32];
      end else if (state_ff == sha1_pkg::ST_ZERO && push_en) begin
         off_in     = 2'd0;
         partial_in = 32'h0;
      end
      if (accept) begin
         bit_len_in = bit_len_ff + {58'd0, in_cnt, 3'b000};
      end
      if (state_ff == sha1_pkg::ST_OUT && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chain[out_idx_ff];
         rsp_last_in  = (out_idx_ff == 3'd4);
         out_idx_in   = (out_idx_ff == 3'd4) ? 3'd0 : out_idx_ff + 3'd1;
      end
      if (ctl.init) begin
         bit_len_in  = 64'd0;
         word_cnt_in = 4'd0;
         off_in      = 2'd0;
         partial_in  = 32'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1_pkg::ST_IDLE;
         resume_ff    <= sha1_pkg::ST_IDLE;
         round_ff     <= 7'd0;
         word_cnt_ff  <= 4'd0;
         off_ff       <= 2'd0;
         partial_ff   <= 32'h0;
         bit_len_ff   <= 64'd0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         round_ff     <= round_in;
         word_cnt_ff  <= word_cnt_in;
         off_ff       <= off_in;
         partial_ff   <= partial_in;
         bit_len_ff   <= bit_len_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // digest payload, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   sha1_sched u_sched (
      .clock      (clock),
      .push_en    (push_en),
      .push_word  (push_word),
      .ctl        (ctl),
      .sched_word (sched_word)
   );

   sha1_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sched_word (sched_word),
      .chain      (chain)
   );

`ifndef ASSERT_OFF
   // round counter only moves inside a compression
   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha1_pkg::ST_ROUND |-> round_ff == 7'd0)
      else $error("round counter moved outside a compression");

   // fold returns to the step that filled the block
   a_fold_resume: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::ST_FOLD |=> state_ff == $past(resume_ff))
      else $error("fold did not resume the interrupted step");

   // length words land exactly at byte 56 of the block
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::ST_LEN_HI |-> word_cnt_ff == 4'd14 && off_ff == 2'd0)
      else $error("length words misplaced in padded block");

   // digest is read only from an empty buffer
   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1_pkg::ST_OUT |-> word_cnt_ff == 4'd0 && off_ff == 2'd0)
      else $error("digest emitted with data left in the buffer");

   // a block enters compression only on its sixteenth word
   a_load_full: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> state_ff == sha1_pkg::ST_ROUND && word_cnt_ff == 4'd0)
      else $error("compression started on a partial block");
`endif

endmodule

`default_nettype wire
